>>> src/lph_pkg.sv
// Shared types, constants and sizes for the linear-probing hash set.
package lph_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
    localparam int SIZE_BITS  = SLOT_BITS + 1;
    localparam int KEY_BITS   = 35;

    localparam int CFG_BITS   = 11;
    localparam logic [CFG_BITS-1:0] TABLE_SIZE_RESET = CFG_BITS'(1024);
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;
    localparam logic REG_TABLE_SIZE = 1'b0;

    // Remainder unit: DIGIT_BITS key bits are folded in per cycle.
    localparam int DIGIT_BITS    = 5;
    localparam int MOD_STEPS     = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int MOD_PAD_BITS  = MOD_STEPS * DIGIT_BITS;
    localparam int MOD_CNT_BITS  = $clog2(MOD_STEPS + 1);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                command;
        logic [KEY_BITS-1:0] key;
    } t_req;

    typedef struct packed {
        logic found;
        logic inserted;
        logic table_full;
    } t_rsp;

    typedef struct packed {
        logic                occupied;
        logic [KEY_BITS-1:0] key;
    } t_entry;

    typedef struct packed {
        logic                 we;
        logic [SLOT_BITS-1:0] addr;
        t_entry               data;
    } t_mem_wr;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_FINISH
    } t_state;

endpackage

>>> src/linear_probe_hash_set.sv
// Top level of the linear-probing hash set: control, configuration and result register.
//
//  Channel | Direction | Handshake                      | Word
//  in      | input     | i_in_valid / o_in_ready        | i_in_data  (t_req)
//  out     | output    | o_out_valid / i_out_ready      | o_out_data (t_rsp)
//  cfg     | input     | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// A word passes through the remainder unit (5 key bits per cycle), then a read of
// the home slot, then one slot visited per probe step, the slot store being read
// once per cycle, and a hand-over to the output register. A word ends when the
// home slot decides, or after up to 1024 probes when the table is nearly full.
// After reset a clearing pass over all 1024 slots empties the store before the
// first word is taken. A word is accepted while the previous result still
// waits in the output register; the finished result waits if that register
// is still full.
module linear_probe_hash_set (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lph_pkg::t_req                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lph_pkg::t_rsp                 o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lph_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lph_pkg::DATA_BITS-1:0] pwdata,
    output logic [lph_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);
    import lph_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic [CFG_BITS-1:0]  r_table_size;
    t_req                 r_req;
    logic [SLOT_BITS-1:0] r_slot;
    logic [SIZE_BITS-1:0] r_visits;
    t_rsp                 r_res;
    logic                 r_out_valid;
    t_rsp                 r_out_data;

    logic [SIZE_BITS-1:0] size_in_use;
    logic                 mod_start;
    logic                 mod_done;
    logic [SLOT_BITS-1:0] mod_rem;
    t_mem_wr              mem_wr;
    logic [SLOT_BITS-1:0] mem_raddr;
    t_entry               mem_rdata;
    logic                 load_out;
    logic                 probe_empty;
    logic                 probe_hit;
    logic                 probe_last;
    logic [SLOT_BITS-1:0] next_slot;
    logic [SIZE_BITS-1:0] visits_inc;
    logic                 cfg_write;
    logic                 is_insert;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TABLE_SIZE);
    assign prdata    = (paddr[2] == REG_TABLE_SIZE) ? DATA_BITS'(r_table_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RESET;
        end else if (cfg_write) begin
            r_table_size <= pwdata[CFG_BITS-1:0];
        end
    end

    // A size of zero means one slot; sizes beyond the store saturate.
    always_comb begin
        if (r_table_size == '0) begin
            size_in_use = SIZE_BITS'(1);
        end else if (32'(r_table_size) > SLOT_COUNT) begin
            size_in_use = SIZE_BITS'(SLOT_COUNT);
        end else begin
            size_in_use = SIZE_BITS'(r_table_size);
        end
    end

    lph_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (i_in_data.key),
        .i_size  (size_in_use),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    lph_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Probe decisions on the entry read in the previous cycle.
    assign is_insert   = (r_req.command == CMD_INSERT);
    assign probe_empty = !mem_rdata.occupied;
    assign probe_hit   = mem_rdata.occupied && (mem_rdata.key == r_req.key);
    assign visits_inc  = r_visits + 1'b1;
    assign probe_last  = (visits_inc == size_in_use);
    assign next_slot   = (SIZE_BITS'(r_slot) + 1'b1 == size_in_use) ? '0
                                                                  : r_slot + 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_slot == SLOT_BITS'(SLOT_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                if (mod_done) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (probe_empty || probe_hit || probe_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        mod_start  = 1'b0;
        load_out   = 1'b0;
        mem_wr     = '0;
        mem_raddr  = next_slot;
        case (r_state)
            ST_CLEAR: begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = r_slot;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                mod_start  = i_in_valid;
            end
            ST_HASH: begin
                mem_raddr = mod_rem;
            end
            ST_PROBE: begin
                if (probe_empty && is_insert) begin
                    mem_wr.we            = 1'b1;
                    mem_wr.addr          = r_slot;
                    mem_wr.data.occupied = 1'b1;
                    mem_wr.data.key      = r_req.key;
                end
            end
            ST_FINISH: begin
                load_out = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_out_valid && !i_out_ready) || load_out;
            if (r_state == ST_CLEAR) begin
                r_slot <= r_slot + 1'b1;
            end else if (r_state == ST_HASH && mod_done) begin
                r_slot <= mod_rem;
            end else if (r_state == ST_PROBE) begin
                r_slot <= next_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req <= i_in_data;
        end
        if (r_state == ST_HASH) begin
            r_visits <= '0;
        end else if (r_state == ST_PROBE) begin
            r_visits <= visits_inc;
        end
        if (r_state == ST_PROBE) begin
            r_res.found      <= probe_hit;
            r_res.inserted   <= probe_empty && is_insert;
            r_res.table_full <= !probe_empty && !probe_hit && probe_last && is_insert;
        end
        if (load_out) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> src/lph_ram.sv
// Slot store: one write port and one read port with registered read data.
module lph_ram (
    input  logic                          i_clk,
    input  lph_pkg::t_mem_wr              i_wr,
    input  logic [lph_pkg::SLOT_BITS-1:0] i_raddr,
    output lph_pkg::t_entry               o_rdata
);
    import lph_pkg::*;

    t_entry mem [SLOT_COUNT];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/lph_mod.sv
// Multi-cycle remainder unit: key modulo table size, several bits per cycle.
module lph_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lph_pkg::KEY_BITS-1:0]  i_key,
    input  logic [lph_pkg::SIZE_BITS-1:0] i_size,
    output logic                          o_done,
    output logic [lph_pkg::SLOT_BITS-1:0] o_rem
);
    import lph_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [MOD_CNT_BITS-1:0] r_cnt;
    logic [MOD_PAD_BITS-1:0] r_key;
    logic [SLOT_BITS-1:0]    r_rem;
    logic [SLOT_BITS-1:0]    n_rem;

    // Restoring steps: the partial remainder stays below the size, so one
    // compare and subtract per bit is enough.
    always_comb begin
        logic [SIZE_BITS-1:0] t;
        logic [SLOT_BITS-1:0] rem;
        rem = r_rem;
        for (int i = 0; i < DIGIT_BITS; i++) begin
            t = {rem, r_key[MOD_PAD_BITS-1-i]};
            if (t >= i_size) begin
                t = t - i_size;
            end
            rem = t[SLOT_BITS-1:0];
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MOD_CNT_BITS'(MOD_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MOD_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= MOD_PAD_BITS'(i_key);
            r_rem <= '0;
        end else if (r_busy) begin
            r_key <= r_key << DIGIT_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> test/tb_linear_probe_hash_set.sv
`timescale 1ns / 1ps
// Self-checking testbench for the linear-probing hash set, with directed and random requests.
module tb_linear_probe_hash_set;
    import lph_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1100;
    localparam int IDLE_GAP       = 4;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_ITEMS    = 52;
    localparam int MAX_REPORTS    = 40;
    localparam logic [ADDR_BITS-1:0] ADDR_TABLE_SIZE = ADDR_BITS'(4 * int'(REG_TABLE_SIZE));
    localparam logic [ADDR_BITS-1:0] ADDR_NO_REG     = ADDR_BITS'(4 * (int'(REG_TABLE_SIZE) + 1));
    localparam logic [KEY_BITS-1:0]  KEY_ONES        = {KEY_BITS{1'b1}};

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_req                 i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_rsp                 o_out_data;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_BITS-1:0] paddr       = '0;
    logic [DATA_BITS-1:0] pwdata      = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    // Shadow of the table and of the size register.
    logic [CFG_BITS-1:0]  size_setting = TABLE_SIZE_RESET;
    bit                   slot_used [SLOT_COUNT];
    logic [KEY_BITS-1:0]  slot_key  [SLOT_COUNT];

    t_req                 req_pending [$];
    t_rsp                 rsp_expected [$];
    logic [KEY_BITS-1:0]  keys_seen [$];

    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    bit  hold_sender   = 1'b0;
    int  quiet_cycles  = 0;
    int  n_accepted    = 0;
    int  n_checked     = 0;
    int  n_stored      = 0;
    int  n_hits        = 0;
    int  n_full        = 0;
    int  n_settings    = 0;
    int  n_errors      = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    linear_probe_hash_set dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    function automatic int slots_in_use();
        int n;
        n = int'(size_setting);
        if (n == 0) n = 1;
        if (n > SLOT_COUNT) n = SLOT_COUNT;
        return n;
    endfunction

    // Walks the shadow table from the home slot and, for an insert, applies it.
    function automatic t_rsp probe_table(t_req r);
        longint unsigned n;
        longint unsigned slot;
        longint unsigned key_val;
        longint unsigned empty_slot;
        longint unsigned visited;
        bit              hit;
        bit              have_empty;
        t_rsp            rsp;
        n          = slots_in_use();
        key_val    = r.key;
        slot       = key_val % n;
        hit        = 1'b0;
        have_empty = 1'b0;
        empty_slot = 0;
        for (visited = 0; visited < n && !hit && !have_empty; visited++) begin
            if (!slot_used[slot]) begin
                have_empty = 1'b1;
                empty_slot = slot;
            end else if (slot_key[slot] == r.key) begin
                hit = 1'b1;
            end else begin
                slot = (slot + 1 == n) ? 0 : slot + 1;
            end
        end
        rsp.found      = hit;
        rsp.inserted   = 1'b0;
        rsp.table_full = 1'b0;
        if (r.command == CMD_INSERT && !hit) begin
            if (have_empty) begin
                slot_key[empty_slot]  = r.key;
                slot_used[empty_slot] = 1'b1;
                rsp.inserted          = 1'b1;
            end else begin
                rsp.table_full = 1'b1;
            end
        end
        return rsp;
    endfunction

    function automatic bit offer_next_word();
        if (req_pending.size() == 0 || hold_sender) return 1'b0;
        return ($urandom_range(99) >= send_idle_pct);
    endfunction

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $realtime, what);
    endtask

    // Request driver: the shadow table is updated as each word is taken.
    always @(posedge i_clk) begin : drive_requests
        t_rsp predicted;
        if (i_in_valid && o_in_ready) begin
            predicted = probe_table(i_in_data);
            rsp_expected.push_back(predicted);
            n_accepted++;
            n_hits   += predicted.found;
            n_stored += predicted.inserted;
            n_full   += predicted.table_full;
            if (offer_next_word())
                i_in_data <= req_pending.pop_front();
            else
                i_in_valid <= 1'b0;
        end else if (!i_in_valid && offer_next_word()) begin
            i_in_data  <= req_pending.pop_front();
            i_in_valid <= 1'b1;
        end
    end

    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin : check_results
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rsp_expected.size() == 0) begin
                report_mismatch("result word with no request outstanding");
            end else begin
                want = rsp_expected.pop_front();
                n_checked++;
                if (o_out_data.found !== want.found)
                    report_mismatch($sformatf("result %0d found %b, expected %b",
                                              n_checked, o_out_data.found, want.found));
                if (o_out_data.inserted !== want.inserted)
                    report_mismatch($sformatf("result %0d inserted %b, expected %b",
                                              n_checked, o_out_data.inserted, want.inserted));
                if (o_out_data.table_full !== want.table_full)
                    report_mismatch($sformatf("result %0d table_full %b, expected %b",
                                              n_checked, o_out_data.table_full,
                                              want.table_full));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d cycles without a word moving, %0d results outstanding",
                     quiet_cycles, rsp_expected.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TABLE_SIZE) size_setting = data[CFG_BITS-1:0];
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        while (req_pending.size() != 0 || i_in_valid || rsp_expected.size() != 0)
            @(negedge i_clk);
        repeat (IDLE_GAP) @(negedge i_clk);
    endtask

    task automatic set_table_size(input logic [DATA_BITS-1:0] data);
        wait_idle();
        write_reg(ADDR_TABLE_SIZE, data);
        n_settings++;
    endtask

    task automatic queue_req(input t_cmd cmd, input logic [KEY_BITS-1:0] key);
        t_req r;
        r.command = cmd;
        r.key     = key;
        req_pending.push_back(r);
        if (cmd == CMD_INSERT) keys_seen.push_back(key);
    endtask

    // Mostly keys that collide on the home slot or were inserted before.
    function automatic logic [KEY_BITS-1:0] pick_key(int n);
        logic [63:0] wide;
        int          kind;
        kind = $urandom_range(99);
        wide = {$urandom, $urandom};
        if (kind < 35 && keys_seen.size() != 0)
            return keys_seen[$urandom_range(keys_seen.size() - 1)];
        if (kind < 65) return KEY_BITS'($urandom_range(n - 1) + n * $urandom_range(7));
        if (kind < 85) return wide[KEY_BITS-1:0];
        if (kind < 93) return KEY_ONES - KEY_BITS'($urandom_range(3 * n));
        return KEY_BITS'($urandom_range(3));
    endfunction

    task automatic random_phase(input int count, input t_idle_mode mode, input bit pause_midway);
        int n;
        int i;
        n = slots_in_use();
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 88;
                stall_pct     = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                stall_pct     = 88;
            end
            default: begin
                send_idle_pct = 35;
                stall_pct     = 35;
            end
        endcase
        for (i = 0; i < count; i++)
            queue_req(($urandom_range(99) < 60) ? CMD_INSERT : CMD_QUERY, pick_key(n));
        if (pause_midway) begin
            while (req_pending.size() > count / 2) @(negedge i_clk);
            hold_sender = 1'b1;
            while (i_in_valid || rsp_expected.size() != 0) @(negedge i_clk);
            hold_sender = 1'b0;
        end
    endtask

    initial begin
        int                   phase_sizes [PHASE_COUNT];
        int                   p;
        logic [DATA_BITS-1:0] word;
        phase_sizes = '{3, 1, 8, 2, 1024, 37, 5, 0, 64, 2047, 16, 100};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset size: collisions, wrap-around at the top slot.
        queue_req(CMD_INSERT, '0);
        queue_req(CMD_INSERT, '0);
        queue_req(CMD_QUERY,  '0);
        queue_req(CMD_QUERY,  KEY_ONES);
        queue_req(CMD_INSERT, KEY_ONES);
        queue_req(CMD_INSERT, KEY_BITS'(1024));
        queue_req(CMD_INSERT, KEY_BITS'(2047));
        queue_req(CMD_QUERY,  KEY_BITS'(2047));
        queue_req(CMD_QUERY,  KEY_BITS'(3071));
        // A size of zero behaves as one slot, which is already taken.
        set_table_size('0);
        queue_req(CMD_INSERT, KEY_BITS'(5));
        queue_req(CMD_QUERY,  KEY_BITS'(5));
        queue_req(CMD_INSERT, '0);
        // Oversized value with the upper word bits set saturates to the full table.
        set_table_size(32'hFFFF_F7FF);
        queue_req(CMD_QUERY,  KEY_BITS'(1024));
        queue_req(CMD_QUERY,  KEY_ONES);
        wait_idle();
        write_reg(ADDR_NO_REG, 32'h0000_0001);
        queue_req(CMD_QUERY,  KEY_BITS'(2047));
        // Shrinking the table hides the key that was stored in slot two.
        set_table_size(32'h5A5A_0802);
        queue_req(CMD_INSERT, KEY_BITS'(7));
        queue_req(CMD_QUERY,  KEY_BITS'(2047));
        queue_req(CMD_QUERY,  KEY_BITS'(1024));
        set_table_size(32'h0000_0001);
        queue_req(CMD_INSERT, KEY_ONES);
        queue_req(CMD_QUERY,  '0);

        for (p = 0; p < PHASE_COUNT; p++) begin
            word = {$urandom} & ~DATA_BITS'(32'h7FF);
            word = word | DATA_BITS'(phase_sizes[p]);
            set_table_size(word);
            if (p == 6) begin
                wait_idle();
                write_reg(ADDR_NO_REG, $urandom);
            end
            random_phase(PHASE_ITEMS, t_idle_mode'(p % 4), p == 2 || p == 7);
        end

        while (req_pending.size() != 0 || i_in_valid || rsp_expected.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d requests over %0d size settings: %0d keys stored, %0d hits, %0d full rejects.",
                 n_accepted, n_settings, n_stored, n_hits, n_full);
        $display("%0d results checked under sender gaps, receiver stalls and a sender pause.",
                 n_checked);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
src/lph_pkg.sv
src/lph_ram.sv
src/lph_mod.sv
src/linear_probe_hash_set.sv
test/tb_linear_probe_hash_set.sv
